// ----- hdl/bps_pkg.sv -----
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants, field layout and types of the Blinn-Phong pixel shader.
// ----------------------------------------------------------------------------
package bps_pkg;

    localparam int COLOR_FRAC_BITS = 12;
    localparam int UNIT_FRAC       = 15;

    localparam int POS_W  = 20;
    localparam int NRM_W  = 16;
    localparam int TEX_W  = 13;
    localparam int COL_W  = 16;
    localparam int VEC_W  = POS_W + 1;
    localparam int UNIT_W = 16;

    localparam int IN_W      = 192;
    localparam int OUT_W     = 3 * COL_W;
    localparam int CFG_W     = 3 * POS_W;
    localparam int CFG_IDX_W = 3;

    localparam int NRM_OFS = 3 * POS_W;
    localparam int DT_OFS  = NRM_OFS + 3 * NRM_W;
    localparam int ST_OFS  = DT_OFS + 3 * TEX_W;

    localparam int SQ_IN_W    = 2 * VEC_W;
    localparam int SQ_STAGES  = VEC_W;
    localparam int DIV_STAGES = UNIT_W;
    localparam int NORM_LAT   = 3 + SQ_STAGES + DIV_STAGES + 1;
    localparam int POW_STEPS  = 8;
    localparam int POW_LAT    = POW_STEPS * (SQ_STAGES + 1) + POW_STEPS;
    localparam int TEX_DLY    = 2 * NORM_LAT + 1 + 2 + POW_LAT;
    localparam int BACK_LAT   = TEX_DLY + 3;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << UNIT_FRAC;
    localparam logic [UNIT_W-1:0] UNIT_MAX = UNIT_ONE - UNIT_W'(1);
    localparam logic [TEX_W-1:0]  COLOR_ONE = TEX_W'(1) << COLOR_FRAC_BITS;
    localparam logic [COL_W-1:0]  SHININESS_RESET = 16'd8192;

    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFFUSE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECULAR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHININESS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXTURED  = 3'd6;

    typedef logic [2:0][VEC_W-1:0]  vec_t;
    typedef logic [2:0][UNIT_W-1:0] unit_vec_t;
    typedef logic [2:0][TEX_W-1:0]  texel_t;

    typedef struct packed {
        vec_t   nrm;
        vec_t   vd;
        vec_t   ld;
        texel_t dt;
        texel_t st;
    } frag_t;

endpackage

// ----- hdl/bps_front.sv -----
// ----------------------------------------------------------------------------
// bps_front
// Accepts fragments, forms view and light directions, resolves texels and
// holds the work in a short queue for the shading pipeline.
// ----------------------------------------------------------------------------
module bps_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bps_pkg::IN_W-1:0]    s_tdata,
    input  logic [bps_pkg::CFG_W-1:0]   camera_position,
    input  logic [bps_pkg::CFG_W-1:0]   light_position,
    input  logic                        textured,
    input  logic                        q_pop,
    output logic                        q_valid,
    output bps_pkg::frag_t              q_frag
);

    localparam int PW = bps_pkg::POS_W;
    localparam int NW = bps_pkg::NRM_W;
    localparam int TW = bps_pkg::TEX_W;
    localparam int VW = bps_pkg::VEC_W;

    bps_pkg::frag_t         frag;
    bps_pkg::frag_t         mem_reg [bps_pkg::QDEPTH];
    logic [bps_pkg::QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [bps_pkg::QAW:0]   count_reg;
    logic                    push;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            frag.nrm[i] = VW'($signed(s_tdata[bps_pkg::NRM_OFS + NW*i +: NW]));
            frag.vd[i]  = {camera_position[PW*i + PW-1], camera_position[PW*i +: PW]}
                        - {s_tdata[PW*i + PW-1], s_tdata[PW*i +: PW]};
            frag.ld[i]  = {light_position[PW*i + PW-1], light_position[PW*i +: PW]}
                        - {s_tdata[PW*i + PW-1], s_tdata[PW*i +: PW]};
            frag.dt[i]  = textured ? s_tdata[bps_pkg::DT_OFS + TW*i +: TW]
                                   : bps_pkg::COLOR_ONE;
            frag.st[i]  = textured ? s_tdata[bps_pkg::ST_OFS + TW*i +: TW]
                                   : bps_pkg::COLOR_ONE;
        end
    end

    assign s_tready = (count_reg != (bps_pkg::QAW+1)'(bps_pkg::QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_frag   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= frag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && q_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/bps_sqrt.sv -----
// ----------------------------------------------------------------------------
// bps_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bps_sqrt (
    input  logic                          aclk,
    input  logic                          en,
    input  logic [bps_pkg::SQ_IN_W-1:0]   radicand,
    output logic [bps_pkg::VEC_W-1:0]     root
);

    localparam int W  = bps_pkg::SQ_IN_W;
    localparam int ST = bps_pkg::SQ_STAGES;

    logic [W-1:0] rem_reg [ST];
    logic [W:0]   res_reg [ST];

    for (genvar k = 0; k < ST; k++) begin : g_stage
        localparam logic [W:0] STEP = (W+1)'(1) << (2*(ST-1-k));
        logic [W-1:0] rem_in;
        logic [W:0]   res_in, trial;

        if (k == 0) begin : g_first
            assign rem_in = radicand;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        assign trial = res_in + STEP;

        always_ff @(posedge aclk) begin
            if (en) begin
                if ({1'b0, rem_in} >= trial) begin
                    rem_reg[k] <= rem_in - trial[W-1:0];
                    res_reg[k] <= (res_in >> 1) + STEP;
                end else begin
                    rem_reg[k] <= rem_in;
                    res_reg[k] <= res_in >> 1;
                end
            end
        end
    end

    assign root = res_reg[ST-1][bps_pkg::VEC_W-1:0];

endmodule

// ----- hdl/bps_norm.sv -----
// ----------------------------------------------------------------------------
// bps_norm
// Pipelined vector normalizer: squares, root, then three restoring dividers
// giving Q1.15 components. A zero vector gives zero.
// ----------------------------------------------------------------------------
module bps_norm (
    input  logic                 aclk,
    input  logic                 en,
    input  bps_pkg::vec_t        vec,
    output bps_pkg::unit_vec_t   unit_vec
);

    localparam int VW      = bps_pkg::VEC_W;
    localparam int UW      = bps_pkg::UNIT_W;
    localparam int DS      = bps_pkg::DIV_STAGES;
    localparam int MAG_DLY = 2 + bps_pkg::SQ_STAGES;

    logic [2:0][VW-1:0]             mag_reg;
    logic [2:0]                     sgn_reg;
    logic [2:0][2*VW-1:0]           sq_reg;
    logic [bps_pkg::SQ_IN_W-1:0]    sum_reg;
    logic [2:0][VW-1:0]             mag_dly_reg [MAG_DLY];
    logic [2:0]                     sgn_dly_reg [MAG_DLY];
    logic [VW-1:0]                  root;

    logic [VW-1:0]  rem_reg [DS][3];
    logic [UW-1:0]  quo_reg [DS][3];
    logic [VW-1:0]  div_reg [DS];
    logic [2:0]     dsg_reg [DS];
    bps_pkg::unit_vec_t out_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sgn_reg[i] <= vec[i][VW-1];
                mag_reg[i] <= vec[i][VW-1] ? -vec[i] : vec[i];
                sq_reg[i]  <= mag_reg[i] * mag_reg[i];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            mag_dly_reg[0] <= mag_reg;
            sgn_dly_reg[0] <= sgn_reg;
            for (int d = 1; d < MAG_DLY; d++) begin
                mag_dly_reg[d] <= mag_dly_reg[d-1];
                sgn_dly_reg[d] <= sgn_dly_reg[d-1];
            end
        end
    end

    bps_sqrt u_sqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (sum_reg),
        .root     (root)
    );

    for (genvar j = 0; j < DS; j++) begin : g_div
        logic [VW-1:0] d_in;
        logic [2:0]    s_in;

        if (j == 0) begin : g_first
            assign d_in = root;
            assign s_in = sgn_dly_reg[MAG_DLY-1];
        end else begin : g_next
            assign d_in = div_reg[j-1];
            assign s_in = dsg_reg[j-1];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[j] <= d_in;
                dsg_reg[j] <= s_in;
            end
        end

        for (genvar i = 0; i < 3; i++) begin : g_lane
            logic [VW:0]   r_in;
            logic [UW-1:0] q_in;
            logic          ge;

            if (j == 0) begin : g_first
                assign r_in = {1'b0, mag_dly_reg[MAG_DLY-1][i]};
                assign q_in = '0;
            end else begin : g_next
                assign r_in = {rem_reg[j-1][i], 1'b0};
                assign q_in = quo_reg[j-1][i];
            end

            assign ge = (r_in >= {1'b0, d_in});

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j][i] <= ge ? VW'(r_in - {1'b0, d_in}) : VW'(r_in);
                    quo_reg[j][i] <= {q_in[UW-2:0], ge};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (div_reg[DS-1] == '0) begin
                    out_reg[i] <= '0;
                end else if (quo_reg[DS-1][i] > bps_pkg::UNIT_MAX) begin
                    out_reg[i] <= dsg_reg[DS-1][i] ? -bps_pkg::UNIT_MAX : bps_pkg::UNIT_MAX;
                end else begin
                    out_reg[i] <= dsg_reg[DS-1][i] ? -quo_reg[DS-1][i] : quo_reg[DS-1][i];
                end
            end
        end
    end

    assign unit_vec = out_reg;

endmodule

// ----- hdl/bps_power.sv -----
// ----------------------------------------------------------------------------
// bps_power
// Pipelined Q1.15 base to Q8.8 exponent: eight repeated square roots for the
// fraction bits, then square-and-multiply for the integer bits.
// ----------------------------------------------------------------------------
module bps_power (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [bps_pkg::UNIT_W-1:0] base,
    input  logic [bps_pkg::COL_W-1:0]  expo,
    output logic [bps_pkg::UNIT_W-1:0] result
);

    localparam int UW = bps_pkg::UNIT_W;
    localparam int EW = bps_pkg::COL_W;
    localparam int NS = bps_pkg::POW_STEPS;
    localparam int SD = bps_pkg::SQ_STAGES;
    localparam int SW = 2*UW + EW;

    logic [UW-1:0] fr_r_reg   [NS];
    logic [UW-1:0] fr_acc_reg [NS];
    logic [UW-1:0] fr_p_reg   [NS];
    logic [EW-1:0] fr_e_reg   [NS];
    logic [SW-1:0] side_reg   [NS][SD];
    logic [bps_pkg::VEC_W-1:0] root [NS];

    logic [UW-1:0] in_acc_reg [NS];
    logic [UW-1:0] in_p_reg   [NS];
    logic [EW-1:0] in_e_reg   [NS];

    for (genvar k = 0; k < NS; k++) begin : g_frac
        logic [UW-1:0]   r_in, acc_d, p_d, rt;
        logic [EW-1:0]   e_d;
        logic [SW-1:0]   side_in;
        logic [2*UW-1:0] prod;

        if (k == 0) begin : g_first
            assign r_in    = base;
            assign side_in = {bps_pkg::UNIT_ONE, expo, base};
        end else begin : g_next
            assign r_in    = fr_r_reg[k-1];
            assign side_in = {fr_acc_reg[k-1], fr_e_reg[k-1], fr_p_reg[k-1]};
        end

        bps_sqrt u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .radicand (bps_pkg::SQ_IN_W'({r_in, {bps_pkg::UNIT_FRAC{1'b0}}})),
            .root     (root[k])
        );

        assign {acc_d, e_d, p_d} = side_reg[k][SD-1];
        assign rt   = root[k][UW-1:0];
        assign prod = acc_d * rt;

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k][0] <= side_in;
                for (int d = 1; d < SD; d++) begin
                    side_reg[k][d] <= side_reg[k][d-1];
                end
                fr_r_reg[k]   <= rt;
                fr_acc_reg[k] <= e_d[NS-1-k] ? UW'(prod >> bps_pkg::UNIT_FRAC) : acc_d;
                fr_p_reg[k]   <= p_d;
                fr_e_reg[k]   <= e_d;
            end
        end
    end

    for (genvar m = 0; m < NS; m++) begin : g_int
        logic [UW-1:0]   acc_i, p_i;
        logic [EW-1:0]   e_i;
        logic [2*UW-1:0] prod_a, prod_p;

        if (m == 0) begin : g_first
            assign acc_i = fr_acc_reg[NS-1];
            assign p_i   = fr_p_reg[NS-1];
            assign e_i   = fr_e_reg[NS-1];
        end else begin : g_next
            assign acc_i = in_acc_reg[m-1];
            assign p_i   = in_p_reg[m-1];
            assign e_i   = in_e_reg[m-1];
        end

        assign prod_a = acc_i * p_i;
        assign prod_p = p_i * p_i;

        always_ff @(posedge aclk) begin
            if (en) begin
                in_acc_reg[m] <= e_i[NS+m] ? UW'(prod_a >> bps_pkg::UNIT_FRAC) : acc_i;
                in_p_reg[m]   <= UW'(prod_p >> bps_pkg::UNIT_FRAC);
                in_e_reg[m]   <= e_i;
            end
        end
    end

    assign result = in_acc_reg[NS-1];

endmodule

// ----- hdl/bps_back.sv -----
// ----------------------------------------------------------------------------
// bps_back
// Shading pipeline: normalizes n, v, l and h, forms the dot factors, raises
// the specular factor and combines the channel terms with saturation.
// ----------------------------------------------------------------------------
module bps_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  bps_pkg::frag_t                q_frag,
    output logic                          q_pop,
    input  logic [bps_pkg::OUT_W-1:0]     light_ambient,
    input  logic [bps_pkg::OUT_W-1:0]     light_diffuse,
    input  logic [bps_pkg::OUT_W-1:0]     light_specular,
    input  logic [bps_pkg::COL_W-1:0]     shininess,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bps_pkg::OUT_W-1:0]     m_color
);

    localparam int UW  = bps_pkg::UNIT_W;
    localparam int VW  = bps_pkg::VEC_W;
    localparam int CW  = bps_pkg::COL_W;
    localparam int TW  = bps_pkg::TEX_W;
    localparam int CF  = bps_pkg::COLOR_FRAC_BITS;
    localparam int NLD = bps_pkg::NORM_LAT + 1;
    localparam int PW  = CW + TW;
    localparam int TS  = CF + bps_pkg::UNIT_FRAC;

    logic en;
    logic [bps_pkg::BACK_LAT-1:0] vld_reg;

    bps_pkg::unit_vec_t n_u, v_u, l_u, h_u;
    bps_pkg::vec_t      hd_reg;
    bps_pkg::unit_vec_t n_nl_reg [NLD];
    bps_pkg::unit_vec_t l_nl_reg [NLD];
    logic [2:0][2*UW-1:0] p_nl_reg, p_hn_reg;
    logic [UW-1:0] ndl, hdn, ndl_reg, hdn_reg, spf;
    logic [UW-1:0] ndl_dly_reg [bps_pkg::POW_LAT];
    bps_pkg::texel_t dt_dly_reg [bps_pkg::TEX_DLY];
    bps_pkg::texel_t st_dly_reg [bps_pkg::TEX_DLY];
    logic [2:0][PW-1:0] amb_p_reg, dif_p_reg, spc_p_reg;
    logic [UW-1:0] ndl_c_reg, spf_c_reg;
    logic [2:0][PW-CF-1:0] amb_reg;
    logic [2:0][PW+UW-TS-1:0] dif_reg, spc_reg;
    logic [bps_pkg::OUT_W-1:0] color_reg;

    assign en      = !vld_reg[bps_pkg::BACK_LAT-1] || m_ready;
    assign q_pop   = en && q_valid;
    assign m_valid = vld_reg[bps_pkg::BACK_LAT-1];
    assign m_color = color_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[bps_pkg::BACK_LAT-2:0], q_pop};
        end
    end

    bps_norm u_norm_n (.aclk(aclk), .en(en), .vec(q_frag.nrm), .unit_vec(n_u));
    bps_norm u_norm_v (.aclk(aclk), .en(en), .vec(q_frag.vd),  .unit_vec(v_u));
    bps_norm u_norm_l (.aclk(aclk), .en(en), .vec(q_frag.ld),  .unit_vec(l_u));
    bps_norm u_norm_h (.aclk(aclk), .en(en), .vec(hd_reg),     .unit_vec(h_u));

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                hd_reg[i] <= VW'($signed(l_u[i])) + VW'($signed(v_u[i]));
            end
            n_nl_reg[0] <= n_u;
            l_nl_reg[0] <= l_u;
            for (int d = 1; d < NLD; d++) begin
                n_nl_reg[d] <= n_nl_reg[d-1];
                l_nl_reg[d] <= l_nl_reg[d-1];
            end
            for (int i = 0; i < 3; i++) begin
                p_nl_reg[i] <= $signed(n_nl_reg[NLD-1][i]) * $signed(l_nl_reg[NLD-1][i]);
                p_hn_reg[i] <= $signed(h_u[i]) * $signed(n_nl_reg[NLD-1][i]);
            end
            ndl_reg <= ndl;
            hdn_reg <= hdn;
        end
    end

    always_comb begin
        logic signed [2*UW+1:0] s_nl, s_hn;
        logic [2*UW+1:0] f_nl, f_hn;
        s_nl = (2*UW+2)'($signed(p_nl_reg[0])) + (2*UW+2)'($signed(p_nl_reg[1]))
             + (2*UW+2)'($signed(p_nl_reg[2]));
        s_hn = (2*UW+2)'($signed(p_hn_reg[0])) + (2*UW+2)'($signed(p_hn_reg[1]))
             + (2*UW+2)'($signed(p_hn_reg[2]));
        f_nl = s_nl >>> bps_pkg::UNIT_FRAC;
        f_hn = s_hn >>> bps_pkg::UNIT_FRAC;
        if (s_nl <= 0) begin
            ndl = '0;
        end else if (f_nl > (2*UW+2)'(bps_pkg::UNIT_ONE)) begin
            ndl = bps_pkg::UNIT_ONE;
        end else begin
            ndl = f_nl[UW-1:0];
        end
        if (s_hn <= 0) begin
            hdn = '0;
        end else if (f_hn > (2*UW+2)'(bps_pkg::UNIT_ONE)) begin
            hdn = bps_pkg::UNIT_ONE;
        end else begin
            hdn = f_hn[UW-1:0];
        end
    end

    bps_power u_power (
        .aclk   (aclk),
        .en     (en),
        .base   (hdn_reg),
        .expo   (shininess),
        .result (spf)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            ndl_dly_reg[0] <= ndl_reg;
            for (int d = 1; d < bps_pkg::POW_LAT; d++) begin
                ndl_dly_reg[d] <= ndl_dly_reg[d-1];
            end
            dt_dly_reg[0] <= q_frag.dt;
            st_dly_reg[0] <= q_frag.st;
            for (int d = 1; d < bps_pkg::TEX_DLY; d++) begin
                dt_dly_reg[d] <= dt_dly_reg[d-1];
                st_dly_reg[d] <= st_dly_reg[d-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [PW+UW-1:0] dp, sp;
        logic [PW+UW-TS:0] sum;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                amb_p_reg[i] <= light_ambient[CW*i +: CW] * dt_dly_reg[bps_pkg::TEX_DLY-1][i];
                dif_p_reg[i] <= light_diffuse[CW*i +: CW] * dt_dly_reg[bps_pkg::TEX_DLY-1][i];
                spc_p_reg[i] <= light_specular[CW*i +: CW] * st_dly_reg[bps_pkg::TEX_DLY-1][i];
            end
            ndl_c_reg <= ndl_dly_reg[bps_pkg::POW_LAT-1];
            spf_c_reg <= spf;
            for (int i = 0; i < 3; i++) begin
                dp = dif_p_reg[i] * ndl_c_reg;
                sp = spc_p_reg[i] * spf_c_reg;
                amb_reg[i] <= amb_p_reg[i][PW-1:CF];
                dif_reg[i] <= dp[PW+UW-1:TS];
                spc_reg[i] <= sp[PW+UW-1:TS];
            end
            for (int i = 0; i < 3; i++) begin
                sum = (PW+UW-TS+1)'(amb_reg[i]) + (PW+UW-TS+1)'(dif_reg[i])
                    + (PW+UW-TS+1)'(spc_reg[i]);
                color_reg[CW*i +: CW] <= (sum > (PW+UW-TS+1)'({CW{1'b1}})) ? {CW{1'b1}}
                                                                          : sum[CW-1:0];
            end
        end
    end

    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid && en)
        else $error("queue popped while empty or stalled");

    a_stall_freezes_dots: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(ndl_reg) && $stable(hdn_reg))
        else $error("dot factors moved during stall");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

// ----- hdl/blinn_phong_pixel_shader.sv -----
// ----------------------------------------------------------------------------
// blinn_phong_pixel_shader
// Blinn-Phong fragment shading in fixed point, one fragment per cycle while m_tready is high.
// ----------------------------------------------------------------------------
// Fragments enter on the s_ stream (position, normal, diffuse and specular
// texels); one shaded color per fragment leaves on the m_ stream in order.
// Camera, light, light colors, shininess and texturing are set through the
// cfg_ write port; the user must use it only while no fragment is in flight;
// the block does not enforce this. The depth from s_ transfer to m_ result
// is set by the four vector normalizers (square root and divider, one bit
// per stage) and the specular power unit (eight chained square roots).
// Throughput is one fragment per cycle while m_tready is high; a four-entry queue separates the
// input side from the shading pipeline.
// When m_tready is low with a result waiting, the shading pipeline holds;
// the queue keeps taking fragments until it is full, then s_tready drops.
// Reset is synchronous and active low: it empties the queue and the
// pipeline and restores the default register values (shininess 32.0).
// ----------------------------------------------------------------------------
module blinn_phong_pixel_shader (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, pos_z, normal_x..z, diffuse_texel r,g,b, specular_texel r,g,b
    input  logic [bps_pkg::IN_W-1:0]        s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // color_red, color_green, color_blue
    output logic [bps_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bps_pkg::CFG_W-1:0]       cfg_wdata
);

    logic [bps_pkg::CFG_W-1:0] camera_reg, light_reg;
    logic [bps_pkg::OUT_W-1:0] ambient_reg, diffuse_reg, specular_reg;
    logic [bps_pkg::COL_W-1:0] shininess_reg;
    logic                      textured_reg;

    logic           q_pop, q_valid;
    bps_pkg::frag_t q_frag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            camera_reg    <= '0;
            light_reg     <= '0;
            ambient_reg   <= '0;
            diffuse_reg   <= '0;
            specular_reg  <= '0;
            shininess_reg <= bps_pkg::SHININESS_RESET;
            textured_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bps_pkg::CFG_CAMERA:    camera_reg    <= cfg_wdata;
                bps_pkg::CFG_LIGHT:     light_reg     <= cfg_wdata;
                bps_pkg::CFG_AMBIENT:   ambient_reg   <= cfg_wdata[bps_pkg::OUT_W-1:0];
                bps_pkg::CFG_DIFFUSE:   diffuse_reg   <= cfg_wdata[bps_pkg::OUT_W-1:0];
                bps_pkg::CFG_SPECULAR:  specular_reg  <= cfg_wdata[bps_pkg::OUT_W-1:0];
                bps_pkg::CFG_SHININESS: shininess_reg <= cfg_wdata[bps_pkg::COL_W-1:0];
                bps_pkg::CFG_TEXTURED:  textured_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    bps_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .camera_position (camera_reg),
        .light_position  (light_reg),
        .textured        (textured_reg),
        .q_pop           (q_pop),
        .q_valid         (q_valid),
        .q_frag          (q_frag)
    );

    bps_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_frag         (q_frag),
        .q_pop          (q_pop),
        .light_ambient  (ambient_reg),
        .light_diffuse  (diffuse_reg),
        .light_specular (specular_reg),
        .shininess      (shininess_reg),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_color        (m_tdata)
    );

endmodule
